// ===== rtl/qn_pkg.sv =====
// Shared types and constants for the quaternion normaliser.
package qn_pkg;

    localparam int DATA_W      = 32;               // one component on either side
    localparam int MAG_W       = 31;               // scaled magnitude, at most 2^30
    localparam int SQ_W        = 2 * MAG_W;        // one square
    localparam int SUM_W       = 64;               // sum of squares, padded to even
    localparam int ROOT_W      = SUM_W / 2;        // integer root, at most 2^31
    localparam int SREM_W      = ROOT_W + 2;       // root cell remainder
    localparam int DREM_W      = ROOT_W + 1;       // divide cell remainder
    localparam int TOL_W       = 31;
    localparam int LANES       = 4;
    localparam int OUT_FRAC_DEF = 30;

    typedef logic [LANES-1:0][MAG_W-1:0] mag4_t;

    // Sign and all-zero marks that travel beside the arithmetic.
    typedef struct packed {
        logic [LANES-1:0] neg;
        logic             zero;
    } tag_t;

endpackage

// ===== rtl/qn_sqrt_cell.sv =====
// One cell of the root chain: settles one root bit per cell.
module qn_sqrt_cell (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        en,
    input  logic                        in_valid,
    input  qn_pkg::tag_t                in_tag,
    input  qn_pkg::mag4_t               in_mag,
    input  logic [qn_pkg::SUM_W-1:0]    in_s,
    input  logic [qn_pkg::SREM_W-1:0]   in_rem,
    input  logic [qn_pkg::ROOT_W-1:0]   in_root,
    output logic                        out_valid,
    output qn_pkg::tag_t                out_tag,
    output qn_pkg::mag4_t               out_mag,
    output logic [qn_pkg::SUM_W-1:0]    out_s,
    output logic [qn_pkg::SREM_W-1:0]   out_rem,
    output logic [qn_pkg::ROOT_W-1:0]   out_root
);
    import qn_pkg::*;

    logic [SREM_W-1:0] rem_sh;
    logic [SREM_W-1:0] trial;
    logic              ge;

    assign rem_sh = {in_rem[SREM_W-3:0], in_s[SUM_W-1 -: 2]};
    assign trial  = {in_root, 2'b01};
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid <= 1'b0;
        end else if (en) begin
            out_valid <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_tag  <= in_tag;
            out_mag  <= in_mag;
            out_s    <= {in_s[SUM_W-3:0], 2'b00};
            out_rem  <= ge ? (rem_sh - trial) : rem_sh;
            out_root <= {in_root[ROOT_W-2:0], ge};
        end
    end

endmodule

// ===== rtl/qn_div_cell.sv =====
// One cell of the divide chain: one quotient bit for all four lanes.
module qn_div_cell #(
    parameter int QW = qn_pkg::OUT_FRAC_DEF + 1
) (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  logic                                      en,
    input  logic                                      in_valid,
    input  qn_pkg::tag_t                              in_tag,
    input  logic [qn_pkg::ROOT_W-1:0]                 in_root,
    input  logic [qn_pkg::LANES-1:0][qn_pkg::DREM_W-1:0] in_rem,
    input  logic [qn_pkg::LANES-1:0][QW-1:0]          in_quo,
    output logic                                      out_valid,
    output qn_pkg::tag_t                              out_tag,
    output logic [qn_pkg::ROOT_W-1:0]                 out_root,
    output logic [qn_pkg::LANES-1:0][qn_pkg::DREM_W-1:0] out_rem,
    output logic [qn_pkg::LANES-1:0][QW-1:0]          out_quo
);
    import qn_pkg::*;

    logic [LANES-1:0]             ge;
    logic [LANES-1:0][DREM_W-1:0] diff;

    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            ge[i]   = (in_rem[i] >= {1'b0, in_root});
            diff[i] = ge[i] ? (in_rem[i] - {1'b0, in_root}) : in_rem[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid <= 1'b0;
        end else if (en) begin
            out_valid <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_tag  <= in_tag;
            out_root <= in_root;
            for (int i = 0; i < LANES; i++) begin
                out_rem[i] <= {diff[i][DREM_W-2:0], 1'b0};
                out_quo[i] <= {in_quo[i][QW-2:0], ge[i]};
            end
        end
    end

endmodule

// ===== rtl/quaternion_normalize.sv =====
// Top level of the quaternion normaliser: front end, root and divide chains, output skid.
//
// Usage
//   s_ channel carries one quaternion per request: tdata holds w, x, y, z, each a
//   signed Q15.16 word, w in the lowest 32 bits. m_ channel returns one request per
//   input: tdata holds the unit-length w, x, y, z in signed Q1.30, tuser is set when
//   all four inputs were zero (the outputs are then zero).
//   cfg_wen / cfg_wdata write the flush tolerance; a result whose magnitude falls
//   below it is forced to zero. Write it only while the block is empty.
// Throughput and structure
//   One request per cycle, sustained while the receiver keeps up. Requests pass
//   through five front stages (magnitude, scaling, squares, two adder levels),
//   32 root cells and one divide cell per quotient bit, then the flush and sign
//   stage, with the output register on top.
// Reset and stall
//   aresetn clears every valid bit and the tolerance; no clearing pass is needed.
//   When the receiver stalls, the output register holds and one more result drops
//   into the skid register; only then does s_tready fall and the pipeline freeze.
module quaternion_normalize #(
    parameter int OUT_FRAC_BITS = qn_pkg::OUT_FRAC_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // w, x, y, z from bit 0 upwards, 32 bits each
    input  logic [4*qn_pkg::DATA_W-1:0]   s_tdata,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // norm_w, norm_x, norm_y, norm_z from bit 0 upwards, 32 bits each
    output logic [4*qn_pkg::DATA_W-1:0]   m_tdata,
    // zero_input
    output logic                          m_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic                          cfg_wen,
    input  logic [qn_pkg::TOL_W-1:0]      cfg_wdata
);
    import qn_pkg::*;

    localparam int QW        = OUT_FRAC_BITS + 1;
    localparam int DIV_STEPS = QW;
    localparam int SQRT_STEPS = ROOT_W;

    // flush tolerance register
    logic [TOL_W-1:0] tol_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tol_reg <= '0;
        end else if (cfg_wen) begin
            tol_reg <= cfg_wdata;
        end
    end

    // pipeline advances while the skid register is empty
    logic skid_valid_reg;
    logic en;

    assign en       = !skid_valid_reg;
    assign s_tready = en;

    // stage 1: magnitudes, signs, large flag, OR of magnitudes
    logic                          v1_reg;
    logic [LANES-1:0][DATA_W-1:0]  mag1_reg;
    tag_t                          tag1_reg;
    logic                          big1_reg;
    logic [DATA_W-1:0]             or1_reg;

    logic [LANES-1:0][DATA_W-1:0]  mag1_next;
    logic [LANES-1:0]              neg1_next;
    logic                          big1_next;
    logic [DATA_W-1:0]             or1_next;

    always_comb begin
        big1_next = 1'b0;
        or1_next  = '0;
        for (int i = 0; i < LANES; i++) begin
            neg1_next[i] = s_tdata[i*DATA_W + DATA_W-1];
            mag1_next[i] = neg1_next[i] ? (~s_tdata[i*DATA_W +: DATA_W] + 1'b1)
                                        : s_tdata[i*DATA_W +: DATA_W];
            big1_next    = big1_next | (mag1_next[i] > (DATA_W'(1) << 30));
            or1_next     = or1_next | mag1_next[i];
        end
    end

    // stage 2: scale so that the largest magnitude sits at 2^29 .. 2^30
    logic        v2_reg;
    mag4_t       mag2_reg;
    tag_t        tag2_reg;
    logic [4:0]  msb;
    logic [4:0]  lsh;
    mag4_t       mag2_next;

    always_comb begin
        msb = '0;
        for (int b = 0; b < DATA_W; b++) begin
            if (or1_reg[b]) begin
                msb = 5'(b);
            end
        end
        lsh = (msb < 5'd29) ? (5'd29 - msb) : 5'd0;
        for (int i = 0; i < LANES; i++) begin
            if (big1_reg) begin
                mag2_next[i] = mag1_reg[i][DATA_W-1:1];
            end else begin
                mag2_next[i] = MAG_W'(mag1_reg[i] << lsh);
            end
        end
    end

    // stage 3: squares; stages 4 and 5: adder tree
    logic                         v3_reg, v4_reg, v5_reg;
    mag4_t                        mag3_reg, mag4_reg, mag5_reg;
    tag_t                         tag3_reg, tag4_reg, tag5_reg;
    logic [LANES-1:0][SQ_W-1:0]   sq3_reg;
    logic [1:0][SQ_W:0]           pair4_reg;
    logic [SUM_W-1:0]             sum5_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mag1_reg      <= mag1_next;
            tag1_reg.neg  <= neg1_next;
            tag1_reg.zero <= (or1_next == '0);
            big1_reg      <= big1_next;
            or1_reg       <= or1_next;

            mag2_reg <= mag2_next;
            tag2_reg <= tag1_reg;

            mag3_reg <= mag2_reg;
            tag3_reg <= tag2_reg;
            for (int i = 0; i < LANES; i++) begin
                sq3_reg[i] <= SQ_W'(mag2_reg[i]) * SQ_W'(mag2_reg[i]);
            end

            mag4_reg     <= mag3_reg;
            tag4_reg     <= tag3_reg;
            pair4_reg[0] <= {1'b0, sq3_reg[0]} + {1'b0, sq3_reg[1]};
            pair4_reg[1] <= {1'b0, sq3_reg[2]} + {1'b0, sq3_reg[3]};

            mag5_reg <= mag4_reg;
            tag5_reg <= tag4_reg;
            sum5_reg <= SUM_W'(pair4_reg[0]) + SUM_W'(pair4_reg[1]);
        end
    end

    // root chain
    logic  [SQRT_STEPS:0]            sq_v;
    tag_t  [SQRT_STEPS:0]            sq_tag;
    mag4_t [SQRT_STEPS:0]            sq_mag;
    logic  [SQRT_STEPS:0][SUM_W-1:0] sq_s;
    logic  [SQRT_STEPS:0][SREM_W-1:0] sq_rem;
    logic  [SQRT_STEPS:0][ROOT_W-1:0] sq_root;

    assign sq_v[0]    = v5_reg;
    assign sq_tag[0]  = tag5_reg;
    assign sq_mag[0]  = mag5_reg;
    assign sq_s[0]    = sum5_reg;
    assign sq_rem[0]  = '0;
    assign sq_root[0] = '0;

    for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_sqrt
        qn_sqrt_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (sq_v[g]),
            .in_tag    (sq_tag[g]),
            .in_mag    (sq_mag[g]),
            .in_s      (sq_s[g]),
            .in_rem    (sq_rem[g]),
            .in_root   (sq_root[g]),
            .out_valid (sq_v[g+1]),
            .out_tag   (sq_tag[g+1]),
            .out_mag   (sq_mag[g+1]),
            .out_s     (sq_s[g+1]),
            .out_rem   (sq_rem[g+1]),
            .out_root  (sq_root[g+1])
        );
    end

    // divide chain
    logic [DIV_STEPS:0]                         dv_v;
    tag_t [DIV_STEPS:0]                         dv_tag;
    logic [DIV_STEPS:0][ROOT_W-1:0]             dv_root;
    logic [DIV_STEPS:0][LANES-1:0][DREM_W-1:0]  dv_rem;
    logic [DIV_STEPS:0][LANES-1:0][QW-1:0]      dv_quo;

    assign dv_v[0]    = sq_v[SQRT_STEPS];
    assign dv_tag[0]  = sq_tag[SQRT_STEPS];
    assign dv_root[0] = sq_root[SQRT_STEPS];
    assign dv_quo[0]  = '0;

    for (genvar i = 0; i < LANES; i++) begin : g_rem0
        assign dv_rem[0][i] = DREM_W'(sq_mag[SQRT_STEPS][i]);
    end

    for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
        qn_div_cell #(.QW(QW)) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (dv_v[g]),
            .in_tag    (dv_tag[g]),
            .in_root   (dv_root[g]),
            .in_rem    (dv_rem[g]),
            .in_quo    (dv_quo[g]),
            .out_valid (dv_v[g+1]),
            .out_tag   (dv_tag[g+1]),
            .out_root  (dv_root[g+1]),
            .out_rem   (dv_rem[g+1]),
            .out_quo   (dv_quo[g+1])
        );
    end

    // final stage: flush small results, apply signs
    logic                         fin_v_reg;
    logic [LANES-1:0][DATA_W-1:0] fin_data_reg;
    logic                         fin_zero_reg;
    logic [LANES-1:0][DATA_W-1:0] fin_data_next;
    logic [DATA_W-1:0]            q_ext;
    logic [DATA_W-1:0]            q_keep;

    always_comb begin
        q_ext  = '0;
        q_keep = '0;
        for (int i = 0; i < LANES; i++) begin
            q_ext  = DATA_W'(dv_quo[DIV_STEPS][i]);
            q_keep = (dv_tag[DIV_STEPS].zero || (q_ext < DATA_W'(tol_reg))) ? '0 : q_ext;
            fin_data_next[i] = dv_tag[DIV_STEPS].neg[i] ? (~q_keep + 1'b1) : q_keep;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fin_v_reg <= 1'b0;
        end else if (en) begin
            fin_v_reg <= dv_v[DIV_STEPS];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            fin_data_reg <= fin_data_next;
            fin_zero_reg <= dv_tag[DIV_STEPS].zero;
        end
    end

    // output register and skid register
    logic                         out_valid_reg;
    logic [LANES*DATA_W-1:0]      out_data_reg;
    logic                         out_zero_reg;
    logic [LANES*DATA_W-1:0]      skid_data_reg;
    logic                         skid_zero_reg;
    logic                         push;

    assign push = en && fin_v_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_tready) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= push;
            end
        end else if (push) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || m_tready) begin
            if (skid_valid_reg) begin
                out_data_reg <= skid_data_reg;
                out_zero_reg <= skid_zero_reg;
            end else begin
                out_data_reg <= fin_data_reg;
                out_zero_reg <= fin_zero_reg;
            end
        end else if (push) begin
            skid_data_reg <= fin_data_reg;
            skid_zero_reg <= fin_zero_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_zero_reg;

endmodule

// ===== rtl/qn_checker.sv =====
// Port-level assertions for the quaternion normaliser, bound to the top level.
module qn_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic [127:0] m_tdata,
    input logic         m_tuser,
    input logic         m_tvalid,
    input logic         m_tready
);

    // hold a stalled request
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == 128'd0)
        else $error("zero input gave non-zero result");

    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |->
            ($signed(m_tdata[31:0])   <= 32'sd1073741824) &&
            ($signed(m_tdata[31:0])   >= -32'sd1073741824) &&
            ($signed(m_tdata[63:32])  <= 32'sd1073741824) &&
            ($signed(m_tdata[63:32])  >= -32'sd1073741824) &&
            ($signed(m_tdata[95:64])  <= 32'sd1073741824) &&
            ($signed(m_tdata[95:64])  >= -32'sd1073741824) &&
            ($signed(m_tdata[127:96]) <= 32'sd1073741824) &&
            ($signed(m_tdata[127:96]) >= -32'sd1073741824))
        else $error("component beyond unit range");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind quaternion_normalize qn_checker u_qn_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);

// ===== verif/tb_quaternion_normalize.sv =====
// Self-checking stream testbench for the quaternion normaliser.
module tb_quaternion_normalize;
    timeunit 1ns;
    timeprecision 1ps;

    import qn_pkg::*;

    localparam int LATENCY   = 6 + 32 + 31;
    localparam int STALL_MAX = 400;
    localparam int WATCHDOG  = 20000;

    typedef struct packed {
        logic [31:0] z;
        logic [31:0] y;
        logic [31:0] x;
        logic [31:0] w;
    } quat_t;

    typedef struct {
        quat_t      unit;
        logic       zero_flag;
    } norm_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic [4*DATA_W-1:0]  s_tdata = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [4*DATA_W-1:0]  m_tdata;
    logic                 m_tuser;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic                 cfg_wen = 1'b0;
    logic [TOL_W-1:0]     cfg_wdata = '0;

    quat_t   pending_quats[$];
    norm_t   expected_norms[$];
    logic [TOL_W-1:0] tolerance = '0;
    int      errors = 0;
    int      send_idle_pct = 0;
    int      recv_stall_pct = 0;
    int      hold_off = 0;
    int      idle_cycles = 0;

    quaternion_normalize uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tdata(s_tdata), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .m_tdata(m_tdata), .m_tuser(m_tuser), .m_tvalid(m_tvalid), .m_tready(m_tready),
        .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata)
    );

    always #5 aclk = ~aclk;

    // Integer root, truncated, by bit-pair subtraction.
    function automatic logic [63:0] root_of(logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bitv;
        res  = '0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    // Scale the quaternion to unit length, flush small parts, restore signs.
    function automatic norm_t normalise(quat_t q);
        norm_t       r;
        logic [31:0] c[4];
        logic [63:0] mag[4];
        logic        neg[4];
        logic [63:0] peak;
        logic [63:0] sumsq;
        logic [63:0] rt;
        logic [63:0] n;
        logic [31:0] o[4];
        c = '{q.w, q.x, q.y, q.z};
        peak = 0;
        for (int i = 0; i < 4; i++) begin
            neg[i] = c[i][31];
            mag[i] = neg[i] ? (64'd1 << 32) - {32'd0, c[i]} : {32'd0, c[i]};
            if (mag[i] > peak) peak = mag[i];
        end
        r.zero_flag = (peak == 0);
        if (peak == 0) begin
            r.unit = '0;
            return r;
        end
        if (peak > (64'd1 << 30)) begin
            for (int i = 0; i < 4; i++) mag[i] >>= 1;
        end else begin
            while (peak < (64'd1 << 29)) begin
                peak <<= 1;
                for (int i = 0; i < 4; i++) mag[i] <<= 1;
            end
        end
        sumsq = 0;
        for (int i = 0; i < 4; i++) sumsq += mag[i] * mag[i];
        rt = root_of(sumsq);
        for (int i = 0; i < 4; i++) begin
            n = (mag[i] << 30) / rt;
            if (n < {33'd0, tolerance}) n = 0;
            if (neg[i]) n = 64'd0 - n;
            o[i] = n[31:0];
        end
        r.unit = '{z: o[3], y: o[2], x: o[1], w: o[0]};
        return r;
    endfunction

    // Driver: advance to the next request once the current one is taken.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (!s_tvalid || s_tready) begin
                if (pending_quats.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_tdata  <= pending_quats.pop_front();
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Predict at the moment of acceptance, with the tolerance then in force.
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready)
            expected_norms.push_back(normalise(quat_t'(s_tdata)));
    end

    // Receiver back-pressure; a long hold-off overrides the random stall.
    always @(posedge aclk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= aresetn && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Monitor: compare each result with the oldest prediction.
    always @(posedge aclk) begin
        norm_t exp_n;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_norms.size() == 0) begin
                $display("%0t: unexpected result %h zero %b", $time, m_tdata, m_tuser);
                errors++;
            end else begin
                exp_n = expected_norms.pop_front();
                if (m_tdata[31:0] !== exp_n.unit.w) begin
                    $display("%0t: w expected %h actual %h", $time, exp_n.unit.w,
                             m_tdata[31:0]);
                    errors++;
                end
                if (m_tdata[63:32] !== exp_n.unit.x) begin
                    $display("%0t: x expected %h actual %h", $time, exp_n.unit.x,
                             m_tdata[63:32]);
                    errors++;
                end
                if (m_tdata[95:64] !== exp_n.unit.y) begin
                    $display("%0t: y expected %h actual %h", $time, exp_n.unit.y,
                             m_tdata[95:64]);
                    errors++;
                end
                if (m_tdata[127:96] !== exp_n.unit.z) begin
                    $display("%0t: z expected %h actual %h", $time, exp_n.unit.z,
                             m_tdata[127:96]);
                    errors++;
                end
                if (m_tuser !== exp_n.zero_flag) begin
                    $display("%0t: zero flag expected %b actual %b", $time,
                             exp_n.zero_flag, m_tuser);
                    errors++;
                end
            end
        end
    end

    // Watchdog: count cycles with no request moving on either side.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG) begin
            $display("tb_quaternion_normalize failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic logic [31:0] rand_comp();
        case ($urandom_range(5))
            0: return $urandom;
            1: return $urandom_range(2000) - 1000;
            2: return 32'h8000_0000 + $urandom_range(3);
            3: return 32'h7FFF_FFFF - $urandom_range(3);
            4: return $urandom >> $urandom_range(31);
            default: return $urandom_range(1) ? 32'h4000_0000 : 32'hC000_0000;
        endcase
    endfunction

    task automatic queue_quat(logic [31:0] w, logic [31:0] x, logic [31:0] y,
                              logic [31:0] z);
        pending_quats.push_back('{z: z, y: y, x: x, w: w});
    endtask

    // Wait until every request has gone in and every result has come out.
    task automatic drain();
        while (pending_quats.size() > 0 || s_tvalid || expected_norms.size() > 0)
            @(posedge aclk);
        repeat (LATENCY + 5) @(posedge aclk);
    endtask

    task automatic write_tolerance(logic [TOL_W-1:0] value);
        @(posedge aclk);
        cfg_wen   <= 1'b1;
        cfg_wdata <= value;
        tolerance <= value;
        @(posedge aclk);
        cfg_wen   <= 1'b0;
    endtask

    task automatic random_phase(int count, int idle_pct, int stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < count; i++)
            queue_quat(rand_comp(), rand_comp(), rand_comp(), rand_comp());
        drain();
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: zero input, extremes, single axes, tiny values, mixed signs.
        queue_quat(0, 0, 0, 0);
        queue_quat(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        queue_quat(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        queue_quat(32'h8000_0000, 0, 0, 0);
        queue_quat(0, 32'h7FFF_FFFF, 0, 0);
        queue_quat(0, 0, 1, 0);
        queue_quat(0, 0, 0, 32'hFFFF_FFFF);
        queue_quat(32'h0001_0000, 0, 0, 0);
        queue_quat(32'h4000_0000, 32'h4000_0001, 0, 0);
        queue_quat(1, 1, 1, 1);
        queue_quat(32'h7FFF_FFFF, 1, 32'hFFFF_FFFF, 32'h8000_0000);
        queue_quat(32'h0001_0000, 32'hFFFF_0000, 32'h0001_0000, 32'hFFFF_0000);
        queue_quat(32'h5555_5555, 32'hAAAA_AAAA, 32'h3333_3333, 32'hCCCC_CCCC);
        queue_quat(32'h2000_0000, 0, 0, 1);
        drain();

        random_phase(300, 0, 0);
        write_tolerance(31'h4000_0000);
        queue_quat(32'h0001_0000, 0, 0, 0);
        queue_quat(1, 1, 1, 1);
        random_phase(150, 54, 0);
        write_tolerance(31'h7FFF_FFFF);
        random_phase(150, 0, 54);
        write_tolerance(31'd1 << 28);
        random_phase(300, 16, 16);
        write_tolerance(31'd12345);
        random_phase(300, 54, 54);

        // Hold off the receiver so the pipeline fills and stalls the sender side.
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_off = STALL_MAX;
        for (int i = 0; i < 150; i++)
            queue_quat(rand_comp(), rand_comp(), rand_comp(), rand_comp());
        drain();

        write_tolerance('0);
        random_phase(480, 16, 16);

        if (errors == 0)
            $display("tb_quaternion_normalize passed");
        else
            $display("tb_quaternion_normalize failed");
        $finish;
    end
endmodule
